>>> sv/opd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// opd_pkg
// Shared types and constants for the Ogg page deframer.
// ----------------------------------------------------------------------------
package opd_pkg;

  localparam int unsigned HDR_LEN      = 27;
  localparam int unsigned HDR_FLAG_POS = 5;
  localparam int unsigned FLAG_CONT    = 0;   // bit index in the flag byte
  localparam int unsigned FLAG_BOS     = 1;   // bit index in the flag byte

  localparam logic [7:0] LACE_FULL = 8'hFF;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_TABLE   = 2'd1,
    KIND_PAYLOAD = 2'd2
  } byte_kind_t;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'b001,
    PH_TABLE   = 3'b010,
    PH_PAYLOAD = 3'b100
  } phase_t;

  typedef enum logic [2:0] {
    ST_RUN   = 3'b001,
    ST_FETCH = 3'b010,
    ST_CHECK = 3'b100
  } ctrl_state_t;

  typedef struct packed {
    logic accept_en;
    logic lookup;
  } ctrl_cmd_t;

  typedef struct packed {
    logic accepted;
    logic need_lookup;
    logic tbl_done;
    logic len_zero;
  } dp_stat_t;

endpackage

>>> sv/ogg_page_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ogg_page_deframer
// Walks an Ogg byte stream page by page and tags every byte.
// ----------------------------------------------------------------------------
// One result beat per input byte. Header, segment table and mid-segment
// payload bytes are taken back to back while the output keeps up. Each
// lacing table lookup adds a memory read state, then a check state, and is
// done at every segment start, once per zero-length entry, and once at the
// end of a page's payload, with the input stalled meanwhile. A flag byte
// whose continued bit disagrees with the open-packet state raises
// page_error; from then on every beat carries page_error until reset.
module ogg_page_deframer
  import opd_pkg::*;
#(
  parameter int MAX_SEGMENTS = 255
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] stream_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] byte_out, [15:8] empty_ends
  output logic [5:0]  out_tuser,  // [1:0] byte_kind, [2] page_begin, [3] stream_begin,
                                  // [4] packet_begin, [5] page_error
  output logic        out_tlast   // packet_end
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  opd_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .cmd   (cmd)
  );

  opd_dpath #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

>>> sv/opd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// opd_ctrl
// Sequencer: runs beats, or walks the lacing table one entry at a time.
// ----------------------------------------------------------------------------
module opd_ctrl
  import opd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RUN;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_RUN: begin
        if (stat.accepted && stat.need_lookup) begin
          state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (!stat.tbl_done && stat.len_zero) begin
          state_nxt = ST_FETCH;
        end else begin
          state_nxt = ST_RUN;
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
  end

  assign cmd.accept_en = (state_r == ST_RUN);
  assign cmd.lookup    = (state_r == ST_CHECK);

endmodule

>>> sv/opd_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// opd_dpath
// Page walker registers, lacing table memory and output register.
// ----------------------------------------------------------------------------
module opd_dpath
  import opd_pkg::*;
#(
  parameter int MAX_SEGMENTS = 255
) (
  input  logic        clk,
  input  logic        rst_n,
  input  ctrl_cmd_t   cmd,
  output dp_stat_t    stat,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,
  output logic [5:0]  out_tuser,
  output logic        out_tlast
);

  localparam int         AW      = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam logic [7:0] MAX_SEG = 8'(MAX_SEGMENTS);

  logic [7:0] lace_mem [MAX_SEGMENTS];
  logic [7:0] rd_data_r;

  phase_t     phase_r,       phase_nxt;
  logic [4:0] header_pos_r,  header_pos_nxt;
  logic [7:0] seg_count_r,   seg_count_nxt;
  logic [7:0] table_pos_r,   table_pos_nxt;
  logic [7:0] bytes_left_r,  bytes_left_nxt;
  logic [7:0] cur_len_r,     cur_len_nxt;
  logic [7:0] empties_r,     empties_nxt;
  logic       packet_open_r, packet_open_nxt;
  logic       halted_r,      halted_nxt;

  logic       out_valid_r,   out_valid_nxt;
  logic [7:0] o_byte_r,      o_byte_nxt;
  byte_kind_t o_kind_r,      o_kind_nxt;
  logic       o_pb_r,        o_pb_nxt;
  logic       o_sb_r,        o_sb_nxt;
  logic       o_kb_r,        o_kb_nxt;
  logic       o_ke_r,        o_ke_nxt;
  logic [7:0] o_empties_r,   o_empties_nxt;
  logic       o_err_r,       o_err_nxt;

  logic       out_free;
  logic       acc;
  logic       mem_we;
  logic       rd_en;
  logic [7:0] tp_inc;
  logic [7:0] bl_dec;
  logic [7:0] seg_sat;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = cmd.accept_en && out_free;
  assign acc       = in_tready && in_tvalid;
  assign tp_inc    = table_pos_r + 8'd1;
  assign bl_dec    = bytes_left_r - 8'd1;
  assign seg_sat   = (in_tdata > MAX_SEG) ? MAX_SEG : in_tdata;
  assign rd_en     = (table_pos_r < MAX_SEG);
  assign mem_we    = acc && !halted_r && (phase_r == PH_TABLE);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      lace_mem[table_pos_r[AW-1:0]] <= in_tdata;
    end
    if (rd_en) begin
      rd_data_r <= lace_mem[table_pos_r[AW-1:0]];
    end
  end

  always_comb begin
    phase_nxt       = phase_r;
    header_pos_nxt  = header_pos_r;
    seg_count_nxt   = seg_count_r;
    table_pos_nxt   = table_pos_r;
    bytes_left_nxt  = bytes_left_r;
    cur_len_nxt     = cur_len_r;
    empties_nxt     = empties_r;
    packet_open_nxt = packet_open_r;
    halted_nxt      = halted_r;

    out_valid_nxt = out_valid_r && !out_tready;
    o_byte_nxt    = o_byte_r;
    o_kind_nxt    = o_kind_r;
    o_pb_nxt      = o_pb_r;
    o_sb_nxt      = o_sb_r;
    o_kb_nxt      = o_kb_r;
    o_ke_nxt      = o_ke_r;
    o_empties_nxt = o_empties_r;
    o_err_nxt     = o_err_r;

    if (acc) begin
      out_valid_nxt = 1'b1;
      o_byte_nxt    = in_tdata;
      o_kind_nxt    = KIND_HEADER;
      o_pb_nxt      = 1'b0;
      o_sb_nxt      = 1'b0;
      o_kb_nxt      = 1'b0;
      o_ke_nxt      = 1'b0;
      o_empties_nxt = empties_r;
      o_err_nxt     = 1'b0;
      empties_nxt   = 8'd0;
      if (halted_r) begin
        o_empties_nxt = 8'd0;
        o_err_nxt     = 1'b1;
      end else begin
        case (phase_r)
          PH_PAYLOAD: begin
            o_kind_nxt = KIND_PAYLOAD;
            if (bytes_left_r == 8'd0) begin
              // first byte of a segment; cur_len is nonzero here
              o_kb_nxt        = !packet_open_r;
              bytes_left_nxt  = cur_len_r - 8'd1;
              packet_open_nxt = 1'b1;
              if (cur_len_r == 8'd1) begin
                table_pos_nxt   = tp_inc;
                o_ke_nxt        = 1'b1;
                packet_open_nxt = 1'b0;
              end
            end else begin
              bytes_left_nxt = bl_dec;
              if (bl_dec == 8'd0) begin
                table_pos_nxt = tp_inc;
                if (cur_len_r != LACE_FULL) begin
                  o_ke_nxt        = 1'b1;
                  packet_open_nxt = 1'b0;
                end
              end
            end
          end
          PH_TABLE: begin
            o_kind_nxt = KIND_TABLE;
            if (tp_inc >= seg_count_r) begin
              phase_nxt      = PH_PAYLOAD;
              table_pos_nxt  = 8'd0;
              bytes_left_nxt = 8'd0;
            end else begin
              table_pos_nxt = tp_inc;
            end
          end
          default: begin
            o_pb_nxt = (header_pos_r == 5'd0);
            if (header_pos_r == 5'(HDR_FLAG_POS)) begin
              o_sb_nxt = in_tdata[FLAG_BOS];
              if (in_tdata[FLAG_CONT] != packet_open_r) begin
                o_err_nxt  = 1'b1;
                halted_nxt = 1'b1;
              end
            end
            if (header_pos_r >= 5'(HDR_LEN - 1)) begin
              seg_count_nxt  = seg_sat;
              header_pos_nxt = 5'd0;
              table_pos_nxt  = 8'd0;
              bytes_left_nxt = 8'd0;
              phase_nxt      = (seg_sat == 8'd0) ? PH_PAYLOAD : PH_TABLE;
            end else begin
              header_pos_nxt = header_pos_r + 5'd1;
              phase_nxt      = PH_HEADER;
            end
          end
        endcase
      end
    end

    if (cmd.lookup) begin
      if (table_pos_r >= seg_count_r) begin
        phase_nxt      = PH_HEADER;
        header_pos_nxt = 5'd0;
      end else if (rd_data_r == 8'd0) begin
        // zero-length segment closes a packet
        empties_nxt     = empties_r + 8'd1;
        table_pos_nxt   = tp_inc;
        packet_open_nxt = 1'b0;
      end else begin
        cur_len_nxt = rd_data_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_HEADER;
      header_pos_r  <= 5'd0;
      seg_count_r   <= 8'd0;
      table_pos_r   <= 8'd0;
      bytes_left_r  <= 8'd0;
      empties_r     <= 8'd0;
      packet_open_r <= 1'b0;
      halted_r      <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      phase_r       <= phase_nxt;
      header_pos_r  <= header_pos_nxt;
      seg_count_r   <= seg_count_nxt;
      table_pos_r   <= table_pos_nxt;
      bytes_left_r  <= bytes_left_nxt;
      empties_r     <= empties_nxt;
      packet_open_r <= packet_open_nxt;
      halted_r      <= halted_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_len_r   <= cur_len_nxt;
    o_byte_r    <= o_byte_nxt;
    o_kind_r    <= o_kind_nxt;
    o_pb_r      <= o_pb_nxt;
    o_sb_r      <= o_sb_nxt;
    o_kb_r      <= o_kb_nxt;
    o_ke_r      <= o_ke_nxt;
    o_empties_r <= o_empties_nxt;
    o_err_r     <= o_err_nxt;
  end

  assign stat.accepted    = acc;
  assign stat.need_lookup = (phase_nxt == PH_PAYLOAD) && (bytes_left_nxt == 8'd0);
  assign stat.tbl_done    = (table_pos_r >= seg_count_r);
  assign stat.len_zero    = (rd_data_r == 8'd0);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {o_empties_r, o_byte_r};
  assign out_tuser  = {o_err_r, o_kb_r, o_sb_r, o_pb_r, o_kind_r};
  assign out_tlast  = o_ke_r;

endmodule

>>> sim/ogg_page_deframer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ogg_page_deframer_test
// Self-checking bench for the Ogg page deframer. Pages are built with
// random header and payload content and sent one byte per beat. A
// predictor tracks the page walk and queues the expected tag of every
// byte. Each output beat is compared against that queue field by field.
// Directed pages cover empty pages, zero-length segments, continued
// packets and a full segment table. Random pages follow, then a long
// output hold. The continuation flag mismatch that halts the block runs
// last.
// ----------------------------------------------------------------------------
module ogg_page_deframer_test;
  import opd_pkg::*;

  localparam int MAX_SEG = 255;

  typedef struct packed {
    logic [7:0] data;
    logic [7:0] empties;
    byte_kind_t kind;
    logic       page_begin;
    logic       stream_begin;
    logic       packet_begin;
    logic       packet_end;
    logic       error;
  } byte_tag_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] stream_byte
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // [7:0] byte_out, [15:8] empty_ends
  logic [5:0]  out_tuser;  // [1:0] byte_kind, [2] page_begin, [3] stream_begin,
                           // [4] packet_begin, [5] page_error
  logic        out_tlast;  // packet_end

  ogg_page_deframer #(.MAX_SEGMENTS(MAX_SEG)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  phase_t     pg_phase = PH_HEADER;
  int         hdr_idx = 0;
  int         seg_total = 0;
  logic [7:0] lace_mem [0:MAX_SEG-1];
  int         lace_idx = 0;
  int         seg_remaining = 0;
  logic       pkt_open = 1'b0;
  logic       locked = 1'b0;

  byte_tag_t  pending_tags[$];
  logic [7:0] lace_plan[$];
  int         bytes_sent = 0;
  int         beat_no = 0;
  int         mismatches = 0;
  bit         idle_on = 1'b1;
  bit         stall_on = 1'b1;
  int         hold_cycles = 0;

  function automatic void tag_byte(input logic [7:0] b);
    byte_tag_t t;
    int        empties;
    int        len;
    t = '0;
    t.data = b;
    t.kind = KIND_HEADER;
    empties = 0;
    if (locked) begin
      t.error = 1'b1;
      pending_tags.push_back(t);
      return;
    end
    if (pg_phase == PH_PAYLOAD && seg_remaining == 0) begin
      while (lace_idx < seg_total && lace_mem[lace_idx] == 8'd0) begin
        empties++;
        lace_idx++;
        pkt_open = 1'b0;
      end
      if (lace_idx >= seg_total) begin
        pg_phase = PH_HEADER;
        hdr_idx = 0;
      end else begin
        t.kind = KIND_PAYLOAD;
        t.empties = empties[7:0];
        t.packet_begin = !pkt_open;
        len = int'(lace_mem[lace_idx]);
        seg_remaining = len - 1;
        pkt_open = 1'b1;
        if (seg_remaining == 0) begin
          lace_idx++;
          if (len < 255) begin
            t.packet_end = 1'b1;
            pkt_open = 1'b0;
          end
        end
        pending_tags.push_back(t);
        return;
      end
    end
    t.empties = empties[7:0];
    case (pg_phase)
      PH_PAYLOAD: begin
        t.kind = KIND_PAYLOAD;
        seg_remaining--;
        if (seg_remaining == 0) begin
          len = int'(lace_mem[lace_idx]);
          lace_idx++;
          if (len < 255) begin
            t.packet_end = 1'b1;
            pkt_open = 1'b0;
          end
        end
      end
      PH_TABLE: begin
        t.kind = KIND_TABLE;
        lace_mem[lace_idx] = b;
        lace_idx++;
        if (lace_idx >= seg_total) begin
          pg_phase = PH_PAYLOAD;
          lace_idx = 0;
          seg_remaining = 0;
        end
      end
      default: begin
        t.page_begin = (hdr_idx == 0);
        if (hdr_idx == HDR_FLAG_POS) begin
          t.stream_begin = b[FLAG_BOS];
          if (b[FLAG_CONT] != pkt_open) begin
            t.error = 1'b1;
            locked = 1'b1;
          end
        end
        if (hdr_idx >= HDR_LEN - 1) begin
          seg_total = (int'(b) > MAX_SEG) ? MAX_SEG : int'(b);
          hdr_idx = 0;
          lace_idx = 0;
          seg_remaining = 0;
          pg_phase = (seg_total == 0) ? PH_PAYLOAD : PH_TABLE;
        end else begin
          hdr_idx++;
          pg_phase = PH_HEADER;
        end
      end
    endcase
    pending_tags.push_back(t);
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < 50) $display("beat %0d: %s", beat_no, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  // called and returns at a falling edge
  task automatic send_byte(input logic [7:0] b);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    tag_byte(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  // sends one page whose segment table is lace_plan
  task automatic send_page(input bit bos, input bit bad_flag);
    logic [7:0] b;
    int         total;
    total = 0;
    for (int i = 0; i < HDR_LEN; i++) begin
      b = 8'($urandom_range(0, 255));
      if (i == HDR_FLAG_POS) begin
        b[FLAG_CONT] = pkt_open ^ bad_flag;
        b[FLAG_BOS]  = bos;
      end
      if (i == HDR_LEN - 1) b = 8'(lace_plan.size());
      send_byte(b);
    end
    foreach (lace_plan[i]) begin
      send_byte(lace_plan[i]);
      total += int'(lace_plan[i]);
    end
    repeat (total) send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic send_random_page();
    int nseg;
    int r;
    r = $urandom_range(0, 15);
    nseg = (r == 0) ? 0 : (r < 12) ? $urandom_range(1, 5) : $urandom_range(6, 24);
    lace_plan.delete();
    repeat (nseg) begin
      r = $urandom_range(0, 39);
      if (r < 7) lace_plan.push_back(8'd0);
      else if (r == 7) lace_plan.push_back(LACE_FULL);
      else if (r == 8) lace_plan.push_back(8'($urandom_range(100, 254)));
      else lace_plan.push_back(8'($urandom_range(1, 12)));
    end
    send_page($urandom_range(0, 7) == 0, 1'b0);
  endtask

  task automatic test_single_packet();
    lace_plan = '{8'd4};
    send_page(1'b1, 1'b0);
  endtask

  task automatic test_empty_page();
    lace_plan.delete();
    send_page(1'b0, 1'b0);
  endtask

  task automatic test_zero_length_segments();
    lace_plan = '{8'd0, 8'd2, 8'd0, 8'd0, 8'd1, 8'd0};
    send_page(1'b0, 1'b0);
  endtask

  task automatic test_continued_packet();
    lace_plan = '{8'd5, LACE_FULL};
    send_page(1'b0, 1'b0);
    lace_plan = '{8'd0, 8'd3};
    send_page(1'b0, 1'b0);
  endtask

  // 255 empty segments
  task automatic test_full_table();
    lace_plan.delete();
    repeat (MAX_SEG) lace_plan.push_back(8'd0);
    send_page(1'b0, 1'b0);
  endtask

  task automatic test_random_stream();
    while (bytes_sent < 750) send_random_page();
  endtask

  // output held off while input keeps coming, then input waits for a full drain
  task automatic test_output_hold();
    idle_on = 1'b0;
    stall_on = 1'b0;
    hold_cycles = 400;
    lace_plan = '{8'd40, 8'd0, 8'd40};
    send_page(1'b0, 1'b0);
    send_random_page();
    in_tvalid <= 1'b0;
    wait (pending_tags.size() == 0);
    @(negedge clk);
    idle_on = 1'b1;
    stall_on = 1'b1;
    repeat (1) send_random_page();
  endtask

  task automatic test_flag_mismatch();
    idle_on = 1'b0;
    stall_on = 1'b0;
    repeat (1) send_random_page();
    lace_plan = '{8'd3};
    send_page(1'b0, 1'b1);
    repeat (20) send_byte(8'($urandom_range(0, 255)));
  endtask

  initial begin : receiver
    int n;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        n = hold_cycles;
        hold_cycles = 0;
        out_tready <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end else if (stall_on && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(0, 15)) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : result_check
    logic [15:0] d;
    logic [5:0]  u;
    logic        l;
    byte_tag_t   want;
    if (rst_n && out_tvalid && out_tready) begin
      d = out_tdata;
      u = out_tuser;
      l = out_tlast;
      #1;
      if (pending_tags.size() == 0) begin
        report_mismatch($sformatf("unexpected beat, byte %0d", d[7:0]));
      end else begin
        want = pending_tags.pop_front();
        check_field("byte_out", int'(d[7:0]), int'(want.data));
        check_field("empty_ends", int'(d[15:8]), int'(want.empties));
        check_field("byte_kind", int'(u[1:0]), int'(want.kind));
        check_field("page_begin", int'(u[2]), int'(want.page_begin));
        check_field("stream_begin", int'(u[3]), int'(want.stream_begin));
        check_field("packet_begin", int'(u[4]), int'(want.packet_begin));
        check_field("page_error", int'(u[5]), int'(want.error));
        check_field("packet_end", int'(l), int'(want.packet_end));
      end
      beat_no++;
    end
  end

  initial begin : watchdog
    #5_000_000;
    $display("ogg_page_deframer_test: FAIL");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = 8'd0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_single_packet();
    test_empty_page();
    test_zero_length_segments();
    test_continued_packet();
    test_full_table();
    test_random_stream();
    test_output_hold();
    test_flag_mismatch();
    in_tvalid <= 1'b0;
    wait (pending_tags.size() == 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("ogg_page_deframer_test: PASS");
    end else begin
      $display("ogg_page_deframer_test: FAIL");
    end
    $finish;
  end

endmodule
